### hdl/fct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_pkg
// Types and codes shared by the frustum cull tester.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned ProdW  = 2 * CoordW;
  localparam int unsigned FracSh = 30;
  localparam int unsigned DistW  = ProdW + 2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BOX    = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE      = 2'd0,
    VERDICT_INTERSECTING = 2'd1,
    VERDICT_INSIDE       = 2'd2,
    VERDICT_RSVD         = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_DIST,
    S_CHK,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] nx;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nz;
    logic signed [CoordW-1:0] w;
  } plane_t;

endpackage

### hdl/frustum_cull_tester.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_tester
// Classifies boxes and spheres against NUM_PLANES stored clipping planes.
// ----------------------------------------------------------------------------
// Planes live in a synchronous plane memory (one read a cycle, registered
// data) and are visited in slot order by one shared evaluator of three
// 32x32 multipliers followed by a two-level adder. Each plane pass runs
// through the multiply, sum, distance and check states; a sphere test makes
// one pass per plane, a box test two (far corner, then near corner). A test
// stops at the first plane that puts it outside (for a box, the first plane
// whose far corner lies behind it). The next word is accepted once the
// verdict has moved into the output register, which may still wait for the
// consumer. Planes read as zero until loaded.
module frustum_cull_tester #(
  parameter int unsigned NUM_PLANES = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  plane_slot_i,
  input  logic signed [31:0] first_x_i,
  input  logic signed [31:0] first_y_i,
  input  logic signed [31:0] first_z_i,
  input  logic signed [31:0] second_x_i,
  input  logic signed [31:0] second_y_i,
  input  logic signed [31:0] second_z_i,
  input  logic signed [31:0] scalar_w_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o
);

  localparam int unsigned AW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int unsigned CW = fct_pkg::CoordW;
  localparam int unsigned PW = fct_pkg::ProdW;
  localparam int unsigned DW = fct_pkg::DistW;
  localparam int unsigned FS = fct_pkg::FracSh;

  fct_pkg::state_e state_q, state_d;

  fct_pkg::plane_t mem [NUM_PLANES];
  logic [NUM_PLANES-1:0] valid_q;
  fct_pkg::plane_t rdata_q;
  logic            rvalid_q;
  fct_pkg::plane_t plane;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          in_fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          is_test;

  logic          box_q;
  logic signed [CW-1:0] first_q  [3];
  logic signed [CW-1:0] second_q [3];
  logic signed [CW-1:0] radius_q;

  logic [AW-1:0] k_q, k_d;
  logic          near_q, near_d;
  logic          cross_q, cross_d;

  logic signed [CW-1:0] nrm [3];
  logic signed [CW-1:0] opnd [3];
  logic signed [PW-1:0] prod_q [3];
  logic signed [DW-1:0] woff_q;
  logic signed [DW-1:0] sa_q, sb_q, dist_q;
  logic signed [DW-1:0] r46, plus, minus;
  logic          dist_neg, plus_neg, plus_pos, minus_neg;

  logic          fin;
  fct_pkg::verdict_e fin_verdict, res_q, verdict_q;
  logic          out_valid_q;
  logic          out_free;
  logic          out_load;

  assign in_ready_o = (state_q == fct_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_test    = (cmd_i == fct_pkg::CMD_BOX) || (cmd_i == fct_pkg::CMD_SPHERE);
  assign wr_addr    = AW'(plane_slot_i);
  assign wr_en      = in_fire && (cmd_i == fct_pkg::CMD_LOAD)
                      && (32'(plane_slot_i) < NUM_PLANES);

  // plane memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{nx: first_x_i, ny: first_y_i, nz: first_z_i, w: scalar_w_i};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= valid_q[rd_addr];
      end
    end
  end

  assign plane = rvalid_q ? rdata_q : '0;

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_fire && is_test) begin
      box_q       <= (cmd_i == fct_pkg::CMD_BOX);
      first_q[0]  <= first_x_i;
      first_q[1]  <= first_y_i;
      first_q[2]  <= first_z_i;
      second_q[0] <= second_x_i;
      second_q[1] <= second_y_i;
      second_q[2] <= second_z_i;
      radius_q    <= scalar_w_i;
    end
  end

  // evaluator
  assign nrm[0] = plane.nx;
  assign nrm[1] = plane.ny;
  assign nrm[2] = plane.nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opnd[i] = (box_q && ((!nrm[i][CW-1]) ^ near_q)) ? second_q[i] : first_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fct_pkg::S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= nrm[i] * opnd[i];
      end
      woff_q <= {{(DW-CW-FS){plane.w[CW-1]}}, plane.w, FS'(0)};
    end
    if (state_q == fct_pkg::S_SUM) begin
      sa_q <= DW'(prod_q[0]) + DW'(prod_q[1]);
      sb_q <= DW'(prod_q[2]) + woff_q;
    end
    if (state_q == fct_pkg::S_DIST) begin
      dist_q <= sa_q + sb_q;
    end
  end

  assign r46       = {{(DW-CW-FS){radius_q[CW-1]}}, radius_q, FS'(0)};
  assign plus      = dist_q + r46;
  assign minus     = dist_q - r46;
  assign dist_neg  = dist_q[DW-1];
  assign plus_neg  = plus[DW-1];
  assign plus_pos  = !plus[DW-1] && (plus != '0);
  assign minus_neg = minus[DW-1];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fct_pkg::S_IDLE;
      k_q     <= '0;
      near_q  <= 1'b0;
      cross_q <= 1'b0;
      res_q   <= fct_pkg::VERDICT_INSIDE;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      near_q  <= near_d;
      cross_q <= cross_d;
      if (fin && !out_load) begin
        res_q <= fin_verdict;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    near_d      = near_q;
    cross_d     = cross_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    fin         = 1'b0;
    fin_verdict = fct_pkg::VERDICT_INSIDE;
    case (state_q)
      fct_pkg::S_IDLE: begin
        if (in_fire && is_test) begin
          rd_en   = 1'b1;
          k_d     = '0;
          near_d  = 1'b0;
          cross_d = 1'b0;
          state_d = fct_pkg::S_MUL;
        end
      end
      fct_pkg::S_MUL:  state_d = fct_pkg::S_SUM;
      fct_pkg::S_SUM:  state_d = fct_pkg::S_DIST;
      fct_pkg::S_DIST: state_d = fct_pkg::S_CHK;
      fct_pkg::S_CHK: begin
        if (box_q && !near_q && dist_neg) begin
          fin         = 1'b1;
          fin_verdict = fct_pkg::VERDICT_OUTSIDE;
        end else if (!box_q && plus_neg) begin
          fin         = 1'b1;
          fin_verdict = fct_pkg::VERDICT_OUTSIDE;
        end else if (box_q && !near_q) begin
          near_d  = 1'b1;
          state_d = fct_pkg::S_MUL;
        end else begin
          if ((box_q && dist_neg) || (!box_q && minus_neg && plus_pos)) begin
            cross_d = 1'b1;
          end
          if (k_q == AW'(NUM_PLANES - 1)) begin
            fin         = 1'b1;
            fin_verdict = (cross_d) ? fct_pkg::VERDICT_INTERSECTING
                                    : fct_pkg::VERDICT_INSIDE;
          end else begin
            k_d     = k_q + 1'b1;
            near_d  = 1'b0;
            rd_en   = 1'b1;
            rd_addr = k_q + 1'b1;
            state_d = fct_pkg::S_MUL;
          end
        end
        if (fin) begin
          state_d = out_free ? fct_pkg::S_IDLE : fct_pkg::S_HOLD;
        end
      end
      fct_pkg::S_HOLD: begin
        fin         = 1'b1;
        fin_verdict = res_q;
        if (out_free) begin
          state_d = fct_pkg::S_IDLE;
        end
      end
      default: state_d = fct_pkg::S_IDLE;
    endcase
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = fin && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= fin_verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

`ifndef SYNTHESIS
  a_busy_after_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (cmd_i == fct_pkg::CMD_BOX || cmd_i == fct_pkg::CMD_SPHERE))
    |=> !in_ready_o)
    else $error("test word did not occupy the evaluator");

  a_hold_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fct_pkg::S_HOLD) |-> out_valid_q)
    else $error("verdict held while output register is free");

  a_verdict_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o == fct_pkg::VERDICT_OUTSIDE
                     || verdict_o == fct_pkg::VERDICT_INTERSECTING
                     || verdict_o == fct_pkg::VERDICT_INSIDE))
    else $error("illegal verdict code");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i == fct_pkg::CMD_LOAD) |=> in_ready_o)
    else $error("load word stalled the block");
`endif

endmodule
